// File: rtl/core/nsmc_pkg.sv
// ----------------------------------------------------------------------------
// nsmc_pkg
// shared constants, codes and types of the ncc stereo matching cost block
// ----------------------------------------------------------------------------
package nsmc_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int ROW_LEN_MAX = MAX_WIDTH + 2;
    localparam int MEM_DEPTH   = 2 * ROW_LEN_MAX;
    localparam int MEM_AW      = $clog2(MEM_DEPTH);
    localparam int COL_W       = $clog2(ROW_LEN_MAX + 1);

    localparam int WIDTH_CFG_W = 11;
    localparam int ROWS_CFG_W  = 13;
    localparam int ROW_W       = ROWS_CFG_W + 1;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 13;

    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);

    localparam logic [15:0] Q_ONE = 16'd16384;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx REG_OUT_WIDTH = 2'd0;
    localparam t_cfg_idx REG_OUT_ROWS  = 2'd1;

    // 3x3 window sums of one interior position
    typedef struct packed {
        logic [11:0] sb;
        logic [11:0] sm;
        logic [19:0] sbb;
        logic [19:0] smm;
        logic [19:0] sbm;
        logic        frame_end;
    } t_win;

    typedef struct packed {
        logic               empty;
        logic [FIFO_CW-1:0] count;
    } t_q_stat;

endpackage

// File: rtl/core/ncc_stereo_matching_cost.sv
// ----------------------------------------------------------------------------
// ncc_stereo_matching_cost
// 3x3 normalized cross-correlation cost over a padded pixel pair raster
// ----------------------------------------------------------------------------
// path: a request that completes a window goes through the line store read
//   and column sum registers and the queue, then divide and sqrt unless flat
// throughput: one pixel request a cycle until queue plus front stages hold 4;
//   the back end takes one window at a time (31-step divide, 16-step sqrt)
// reset: synchronous active low; then a clearing pass over all 2052 line
//   store words during which input stays stalled (config writes are taken)
module ncc_stereo_matching_cost (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [nsmc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [nsmc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [7:0]                       i_base_pixel,
    input  logic [7:0]                       i_match_pixel,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [15:0]                      o_cost,
    output logic                             o_flat_window,
    output logic                             o_frame_end
);

    nsmc_pkg::t_q_stat w_q_stat;
    nsmc_pkg::t_win    w_push_data, w_pop_data;
    logic              w_push, w_pop;

    nsmc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_base_pixel (i_base_pixel),
        .i_match_pixel(i_match_pixel),
        .i_q_stat     (w_q_stat),
        .o_push       (w_push),
        .o_push_data  (w_push_data)
    );

    nsmc_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_push_data(w_push_data),
        .i_pop      (w_pop),
        .o_pop_data (w_pop_data),
        .o_stat     (w_q_stat)
    );

    nsmc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_stat     (w_q_stat),
        .i_pop_data   (w_pop_data),
        .o_pop        (w_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_cost       (o_cost),
        .o_flat_window(o_flat_window),
        .o_frame_end  (o_frame_end)
    );

endmodule

// File: rtl/core/nsmc_front.sv
// ----------------------------------------------------------------------------
// nsmc_front
// raster position, line store, column sums and window sums per request
// ----------------------------------------------------------------------------
module nsmc_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [nsmc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [nsmc_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [7:0]                           i_base_pixel,
    input  logic [7:0]                           i_match_pixel,
    input  nsmc_pkg::t_q_stat                    i_q_stat,
    output logic                                 o_push,
    output nsmc_pkg::t_win                       o_push_data
);

    logic [nsmc_pkg::WIDTH_CFG_W-1:0] r_out_width;
    logic [nsmc_pkg::ROWS_CFG_W-1:0]  r_out_rows;
    logic [nsmc_pkg::COL_W-1:0]       r_col;
    logic [nsmc_pkg::ROW_W-1:0]       r_row;
    logic                             r_slot;
    logic                             r_clr_busy;
    logic [nsmc_pkg::MEM_AW-1:0]      r_clr_addr;

    logic [15:0] r_mem [nsmc_pkg::MEM_DEPTH];
    logic [15:0] r_rd_old;
    logic [15:0] r_rd_new;

    logic       r_v1, r_win1, r_fe1;
    logic [7:0] r_b1, r_m1;
    logic       r_v2, r_fe2;

    logic [9:0]  r_cb  [3];
    logic [9:0]  r_cm  [3];
    logic [17:0] r_cbb [3];
    logic [17:0] r_cmm [3];
    logic [17:0] r_cbm [3];

    logic [nsmc_pkg::WIDTH_CFG_W-1:0] w_width;
    logic [nsmc_pkg::ROWS_CFG_W-1:0]  w_rows;
    logic [nsmc_pkg::COL_W-1:0]       w_row_len;
    logic [nsmc_pkg::ROW_W-1:0]       w_frame_rows;
    logic [nsmc_pkg::COL_W-1:0]       w_c;
    logic [nsmc_pkg::COL_W-1:0]       n_c;
    logic [nsmc_pkg::ROW_W-1:0]       w_r;
    logic [nsmc_pkg::ROW_W-1:0]       n_r;
    logic [nsmc_pkg::MEM_AW-1:0]      w_old_addr, w_new_addr, w_wr_addr;
    logic [15:0]                      w_wr_data;
    logic                             w_we, w_accept;
    logic [nsmc_pkg::FIFO_CW-1:0]     w_pending;

    logic [9:0]  w_sb, w_sm;
    logic [17:0] w_sbb, w_smm, w_sbm;
    logic [7:0]  w_b0, w_b1, w_m0, w_m1;

    always_comb begin
        if (r_out_width == '0) begin
            w_width = nsmc_pkg::WIDTH_CFG_W'(1);
        end else if (r_out_width > nsmc_pkg::WIDTH_CFG_W'(nsmc_pkg::MAX_WIDTH)) begin
            w_width = nsmc_pkg::WIDTH_CFG_W'(nsmc_pkg::MAX_WIDTH);
        end else begin
            w_width = r_out_width;
        end
        w_rows       = (r_out_rows == '0) ? nsmc_pkg::ROWS_CFG_W'(1) : r_out_rows;
        w_row_len    = nsmc_pkg::COL_W'(w_width) + nsmc_pkg::COL_W'(2);
        w_frame_rows = nsmc_pkg::ROW_W'(w_rows) + nsmc_pkg::ROW_W'(2);
        w_c          = (r_col >= w_row_len) ? '0 : r_col;
        w_r          = (r_row >= w_frame_rows) ? '0 : r_row;
        n_c          = w_c + nsmc_pkg::COL_W'(1);
        n_r          = (w_r + nsmc_pkg::ROW_W'(1) >= w_frame_rows) ? '0
                     : w_r + nsmc_pkg::ROW_W'(1);
        w_old_addr   = r_slot ? nsmc_pkg::MEM_AW'(nsmc_pkg::ROW_LEN_MAX) + nsmc_pkg::MEM_AW'(w_c)
                              : nsmc_pkg::MEM_AW'(w_c);
        w_new_addr   = r_slot ? nsmc_pkg::MEM_AW'(w_c)
                              : nsmc_pkg::MEM_AW'(nsmc_pkg::ROW_LEN_MAX) + nsmc_pkg::MEM_AW'(w_c);
    end

    // room in the queue for everything already on its way
    assign w_pending  = i_q_stat.count + nsmc_pkg::FIFO_CW'(r_v1) + nsmc_pkg::FIFO_CW'(r_v2);
    assign o_in_stall = r_clr_busy || (w_pending >= nsmc_pkg::FIFO_CW'(nsmc_pkg::FIFO_DEPTH));
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_we      = r_clr_busy || w_accept;
    assign w_wr_addr = r_clr_busy ? r_clr_addr : w_old_addr;
    assign w_wr_data = r_clr_busy ? 16'd0 : {i_match_pixel, i_base_pixel};

    always_ff @(posedge i_clk) begin
        r_rd_old <= r_mem[w_old_addr];
        r_rd_new <= r_mem[w_new_addr];
        if (w_we) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_width <= nsmc_pkg::WIDTH_CFG_W'(640);
            r_out_rows  <= nsmc_pkg::ROWS_CFG_W'(480);
            r_col       <= '0;
            r_row       <= '0;
            r_slot      <= 1'b0;
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + nsmc_pkg::MEM_AW'(1);
                if (r_clr_addr == nsmc_pkg::MEM_AW'(nsmc_pkg::MEM_DEPTH - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (i_cfg_we && (i_cfg_index == nsmc_pkg::REG_OUT_WIDTH ||
                             i_cfg_index == nsmc_pkg::REG_OUT_ROWS)) begin
                if (i_cfg_index == nsmc_pkg::REG_OUT_WIDTH) begin
                    r_out_width <= i_cfg_data[nsmc_pkg::WIDTH_CFG_W-1:0];
                end else begin
                    r_out_rows <= i_cfg_data[nsmc_pkg::ROWS_CFG_W-1:0];
                end
                r_col  <= '0;
                r_row  <= '0;
                r_slot <= 1'b0;
            end else if (w_accept) begin
                if (n_c >= w_row_len) begin
                    r_col  <= '0;
                    r_slot <= ~r_slot;
                    r_row  <= n_r;
                end else begin
                    r_col <= n_c;
                    r_row <= w_r;
                end
            end
            r_v1 <= w_accept;
            r_v2 <= r_v1 && r_win1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b1   <= i_base_pixel;
        r_m1   <= i_match_pixel;
        r_win1 <= (w_r >= nsmc_pkg::ROW_W'(2)) && (w_c >= nsmc_pkg::COL_W'(2));
        r_fe1  <= (w_r == w_frame_rows - nsmc_pkg::ROW_W'(1)) &&
                  (w_c == w_row_len - nsmc_pkg::COL_W'(1));
        r_fe2  <= r_fe1;
    end

    // column sums of the three rows at this column
    always_comb begin
        w_b0  = r_rd_old[7:0];
        w_m0  = r_rd_old[15:8];
        w_b1  = r_rd_new[7:0];
        w_m1  = r_rd_new[15:8];
        w_sb  = 10'(w_b0) + 10'(w_b1) + 10'(r_b1);
        w_sm  = 10'(w_m0) + 10'(w_m1) + 10'(r_m1);
        w_sbb = 18'(w_b0 * w_b0) + 18'(w_b1 * w_b1) + 18'(r_b1 * r_b1);
        w_smm = 18'(w_m0 * w_m0) + 18'(w_m1 * w_m1) + 18'(r_m1 * r_m1);
        w_sbm = 18'(w_b0 * w_m0) + 18'(w_b1 * w_m1) + 18'(r_b1 * r_m1);
    end

    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_cb[0]  <= r_cb[1];   r_cb[1]  <= r_cb[2];   r_cb[2]  <= w_sb;
            r_cm[0]  <= r_cm[1];   r_cm[1]  <= r_cm[2];   r_cm[2]  <= w_sm;
            r_cbb[0] <= r_cbb[1];  r_cbb[1] <= r_cbb[2];  r_cbb[2] <= w_sbb;
            r_cmm[0] <= r_cmm[1];  r_cmm[1] <= r_cmm[2];  r_cmm[2] <= w_smm;
            r_cbm[0] <= r_cbm[1];  r_cbm[1] <= r_cbm[2];  r_cbm[2] <= w_sbm;
        end
    end

    assign o_push = r_v2;
    always_comb begin
        o_push_data.sb  = 12'(r_cb[0]) + 12'(r_cb[1]) + 12'(r_cb[2]);
        o_push_data.sm  = 12'(r_cm[0]) + 12'(r_cm[1]) + 12'(r_cm[2]);
        o_push_data.sbb = 20'(r_cbb[0]) + 20'(r_cbb[1]) + 20'(r_cbb[2]);
        o_push_data.smm = 20'(r_cmm[0]) + 20'(r_cmm[1]) + 20'(r_cmm[2]);
        o_push_data.sbm = 20'(r_cbm[0]) + 20'(r_cbm[1]) + 20'(r_cbm[2]);
        o_push_data.frame_end = r_fe2;
    end

endmodule

// File: rtl/core/nsmc_fifo.sv
// ----------------------------------------------------------------------------
// nsmc_fifo
// short queue of window sums between front and back
// ----------------------------------------------------------------------------
module nsmc_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  nsmc_pkg::t_win     i_push_data,
    input  logic               i_pop,
    output nsmc_pkg::t_win     o_pop_data,
    output nsmc_pkg::t_q_stat  o_stat
);

    nsmc_pkg::t_win                r_mem [nsmc_pkg::FIFO_DEPTH];
    logic [nsmc_pkg::FIFO_AW-1:0]  r_wp, r_rp;
    logic [nsmc_pkg::FIFO_CW-1:0]  r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + nsmc_pkg::FIFO_AW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + nsmc_pkg::FIFO_AW'(1);
            end
            r_cnt <= r_cnt + nsmc_pkg::FIFO_CW'(i_push) - nsmc_pkg::FIFO_CW'(i_pop);
        end
    end

    assign o_pop_data   = r_mem[r_rp];
    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.count = r_cnt;

endmodule

// File: rtl/core/nsmc_back.sv
// ----------------------------------------------------------------------------
// nsmc_back
// variance terms, bit-serial ratio divide and square root, output register
// ----------------------------------------------------------------------------
module nsmc_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  nsmc_pkg::t_q_stat  i_q_stat,
    input  nsmc_pkg::t_win     i_pop_data,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [15:0]        o_cost,
    output logic               o_flat_window,
    output logic               o_frame_end
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SQ   = 6'b000010,
        S_PROD = 6'b000100,
        S_DIV  = 6'b001000,
        S_SQRT = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state         r_state;
    nsmc_pkg::t_win r_win;
    logic [24:0]    r_a, r_bb, r_num;
    logic [45:0]    r_p;
    logic [47:0]    r_rem;
    logic           r_neg;
    logic [30:0]    r_quo;
    logic [4:0]     r_cnt;
    logic [31:0]    r_src;
    logic [15:0]    r_root;
    logic [17:0]    r_srem;
    logic [15:0]    r_cost;
    logic           r_flat;

    logic [24:0] w_a, w_bb, w_num;
    logic [24:0] w_abs;
    logic        w_flat;
    logic        w_dge;
    logic [47:0] w_diff;
    logic [30:0] w_quo_next;
    logic [17:0] w_cur, w_trial;
    logic        w_sge;
    logic [15:0] w_root_next;
    logic [16:0] w_half;

    // 9*sum_sq - sum*sum, two's complement over 25 bits
    always_comb begin
        w_a   = 25'({r_win.sbb, 3'b000}) + 25'(r_win.sbb) - 25'(r_win.sb * r_win.sb);
        w_bb  = 25'({r_win.smm, 3'b000}) + 25'(r_win.smm) - 25'(r_win.sm * r_win.sm);
        w_num = 25'({r_win.sbm, 3'b000}) + 25'(r_win.sbm) - 25'(r_win.sb * r_win.sm);
        w_abs = r_num[24] ? (25'd0 - r_num) : r_num;
        w_flat = r_a[24] || (r_a == '0) || r_bb[24] || (r_bb == '0);

        w_dge      = (r_rem >= {2'b00, r_p});
        w_diff     = w_dge ? (r_rem - {2'b00, r_p}) : r_rem;
        w_quo_next = {r_quo[29:0], w_dge};

        w_cur       = {r_srem[15:0], r_src[31:30]};
        w_trial     = {r_root, 2'b01};
        w_sge       = (w_cur >= w_trial);
        w_root_next = {r_root[14:0], w_sge};
        w_half      = (17'(w_root_next) + 17'd1) >> 1;
    end

    assign o_pop = (r_state == S_IDLE) && !i_q_stat.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (!i_q_stat.empty) begin
                        r_state <= S_SQ;
                    end
                end
                S_SQ:   r_state <= S_PROD;
                S_PROD: r_state <= w_flat ? S_OUT : S_DIV;
                S_DIV: begin
                    if (r_cnt == 5'd30) begin
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (r_cnt == 5'd15) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!i_out_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_win <= i_pop_data;
            end
            S_SQ: begin
                r_a   <= w_a;
                r_bb  <= w_bb;
                r_num <= w_num;
            end
            S_PROD: begin
                r_p    <= r_a[22:0] * r_bb[22:0];
                r_rem  <= 48'(w_abs[22:0] * w_abs[22:0]);
                r_neg  <= r_num[24];
                r_quo  <= '0;
                r_cnt  <= '0;
                r_cost <= nsmc_pkg::Q_ONE;
                r_flat <= w_flat;
            end
            S_DIV: begin
                // restoring divide of n2 * 2^30 by p, one quotient bit a cycle
                r_rem <= {w_diff[46:0], 1'b0};
                r_quo <= w_quo_next;
                if (r_cnt == 5'd30) begin
                    r_cnt  <= '0;
                    r_src  <= {1'b0, w_quo_next};
                    r_root <= '0;
                    r_srem <= '0;
                end else begin
                    r_cnt <= r_cnt + 5'd1;
                end
            end
            S_SQRT: begin
                r_srem <= w_sge ? (w_cur - w_trial) : w_cur;
                r_root <= w_root_next;
                r_src  <= {r_src[29:0], 2'b00};
                r_cnt  <= r_cnt + 5'd1;
                if (r_cnt == 5'd15) begin
                    // halving the integer root with rounding gives the magnitude
                    r_cost <= r_neg ? nsmc_pkg::Q_ONE + w_half[15:0]
                                    : nsmc_pkg::Q_ONE - w_half[15:0];
                end
            end
            S_OUT: begin
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid   = (r_state == S_OUT);
    assign o_cost        = r_cost;
    assign o_flat_window = r_flat;
    assign o_frame_end   = r_win.frame_end;

endmodule

// File: rtl/core/nsmc_check.sv
// ----------------------------------------------------------------------------
// nsmc_check
// port-level checks of the ncc stereo matching cost block
// ----------------------------------------------------------------------------
module nsmc_check (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_in_stall,
    input  logic        o_out_valid,
    input  logic        i_out_stall,
    input  logic [15:0] o_cost,
    input  logic        o_flat_window,
    input  logic        o_frame_end
);

    // line store clearing keeps the input closed right after reset
    a_stall_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall) else $error("input open after reset");

    a_no_out_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid) else $error("result right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_cost)
            && $stable(o_flat_window) && $stable(o_frame_end))
        else $error("stalled result changed");

    a_cost_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_cost <= 16'd32768) else $error("cost out of range");

    a_flat_cost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_flat_window |-> o_cost == 16'd16384)
        else $error("flat window without unit cost");

endmodule

bind ncc_stereo_matching_cost nsmc_check u_nsmc_check (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_cost       (o_cost),
    .o_flat_window(o_flat_window),
    .o_frame_end  (o_frame_end)
);
